/* src/ufb_pkg.sv */
// Shared types and constants for the UDP/IPv4 frame builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ufb_pkg;

   // Frame limits and field widths
   localparam int unsigned MAX_PAYLOAD = 1400;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned HDR_BYTES   = 42;
   localparam int unsigned IDX_W       = $clog2(HDR_BYTES);
   localparam int unsigned CSUM_W      = 19;

   // Input opcodes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_MAC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATEWAY_MAC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_IP   = 2'd2;

   // Register reset values
   localparam logic [47:0] LOCAL_MAC_RST   = 48'h0;
   localparam logic [47:0] GATEWAY_MAC_RST = 48'd90525193470466;
   localparam logic [31:0] SOURCE_IP_RST   = 32'h0A00020F;

   // Ephemeral port range
   localparam logic [15:0] EPH_MIN = 16'd49152;
   localparam logic [15:0] EPH_MAX = 16'd65535;

   // Header constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
   localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
   // Constant part of the IPv4 checksum: 0x4500 + 0x4011 + 28 (length offset)
   localparam logic [CSUM_W-1:0] CSUM_SEED = CSUM_W'(32'h4500 + 32'h4011 + 32'd28);

   // Command queue and result queue depths
   localparam int unsigned CMD_DEPTH = 2;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int unsigned OUT_DEPTH = 2;
   localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_HDR,
      CMD_DATA,
      CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [31:0]      dest_ip;
      logic [15:0]      dest_port;
      logic [15:0]      source_port;
      logic [LEN_W-1:0] payload_len;
      logic [7:0]       data;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
      logic       error;
   } rsp_type;

   typedef struct packed {
      logic [47:0] local_mac;
      logic [47:0] gateway_mac;
      logic [31:0] source_ip;
   } cfg_type;

endpackage

`default_nettype wire

/* src/ufb_front.sv */
// Front end: accepts request beats, checks them and turns them into commands.
// Holds the open-frame byte count and the ephemeral port counter. Uses ufb_pkg.
`default_nettype none

module ufb_front
   import ufb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic             req_opcode,
   input  wire logic [31:0]      req_dest_ip,
   input  wire logic [15:0]      req_dest_port,
   input  wire logic [15:0]      req_source_port,
   input  wire logic [LEN_W-1:0] req_payload_len,
   input  wire logic [7:0]       req_payload_byte,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output cmd_type               cmd_data
);

   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [15:0]      eph_ff, eph_in;
   logic             bad_start;

   assign cmd_push  = req_push && !cmd_full;
   assign bad_start = (req_payload_len > LEN_W'(MAX_PAYLOAD)) || (req_dest_port == 16'd0) ||
                      (req_dest_ip == 32'd0) || (rem_ff != '0);

   always_comb begin
      rem_in                  = rem_ff;
      eph_in                  = eph_ff;
      cmd_data                = '0;
      cmd_data.kind           = CMD_ERR;
      cmd_data.dest_ip        = req_dest_ip;
      cmd_data.dest_port      = req_dest_port;
      cmd_data.source_port    = req_source_port;
      cmd_data.payload_len    = req_payload_len;
      cmd_data.data           = req_payload_byte;
      if (req_opcode == OP_PAYLOAD) begin
         if (rem_ff != '0) begin
            cmd_data.kind = CMD_DATA;
            cmd_data.last = (rem_ff == LEN_W'(1));
            rem_in        = rem_ff - LEN_W'(1);
         end
      end else if (!bad_start) begin
         cmd_data.kind = CMD_HDR;
         rem_in        = req_payload_len;
         if (req_source_port == 16'd0) begin
            cmd_data.source_port = eph_ff;
            eph_in = (eph_ff == EPH_MAX) ? EPH_MIN : eph_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         eph_ff <= EPH_MIN;
      end else if (cmd_push) begin
         rem_ff <= rem_in;
         eph_ff <= eph_in;
      end
   end

endmodule

`default_nettype wire

/* src/ufb_cmd_queue.sv */
// Short command queue between the front end and the header sequencer.
// Register storage, full flag from the count. Uses ufb_pkg.
`default_nettype none

module ufb_cmd_queue
   import ufb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_data,
   input  wire logic pop,
   output logic      full,
   output logic      empty,
   output cmd_type   head
);

   cmd_type                slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ff, rd_ff;
   logic [CMD_CNT_W-1:0]   cnt_ff;

   assign full  = (cnt_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ff + CMD_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ff + CMD_PTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CMD_CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CMD_CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* src/ufb_back.sv */
// Back end: expands header commands into 42 bytes, passes data and error beats.
// Folds the IPv4 checksum over the first header bytes. Uses ufb_pkg.
`default_nettype none

module ufb_back
   import ufb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   input  wire logic cmd_empty,
   input  cmd_type   cmd_head,
   input  wire logic out_room,
   output logic      cmd_pop,
   output logic      out_push,
   output rsp_type   out_data
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_HDR  = 2'b10
   } back_state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_BYTES - 1);

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CSUM_W-1:0] sum_ff, sum_in;
   logic [31:0]       dip_ff;
   logic [15:0]       dport_ff, sport_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              load;
   logic [15:0]       tot_len, udp_len, csum;
   logic [7:0]        hdr_byte;

   assign tot_len = 16'(len_ff) + IP_UDP_HDR_LEN;
   assign udp_len = 16'(len_ff) + UDP_HDR_LEN;
   assign csum    = ~sum_ff[15:0];

   always_comb begin
      case (idx_ff)
         6'd0:    hdr_byte = cfg.gateway_mac[47:40];
         6'd1:    hdr_byte = cfg.gateway_mac[39:32];
         6'd2:    hdr_byte = cfg.gateway_mac[31:24];
         6'd3:    hdr_byte = cfg.gateway_mac[23:16];
         6'd4:    hdr_byte = cfg.gateway_mac[15:8];
         6'd5:    hdr_byte = cfg.gateway_mac[7:0];
         6'd6:    hdr_byte = cfg.local_mac[47:40];
         6'd7:    hdr_byte = cfg.local_mac[39:32];
         6'd8:    hdr_byte = cfg.local_mac[31:24];
         6'd9:    hdr_byte = cfg.local_mac[23:16];
         6'd10:   hdr_byte = cfg.local_mac[15:8];
         6'd11:   hdr_byte = cfg.local_mac[7:0];
         6'd12:   hdr_byte = ETHERTYPE_IPV4[15:8];
         6'd13:   hdr_byte = ETHERTYPE_IPV4[7:0];
         6'd14:   hdr_byte = IP_VER_IHL;
         6'd16:   hdr_byte = tot_len[15:8];
         6'd17:   hdr_byte = tot_len[7:0];
         6'd22:   hdr_byte = IP_TTL;
         6'd23:   hdr_byte = IP_PROTO_UDP;
         6'd24:   hdr_byte = csum[15:8];
         6'd25:   hdr_byte = csum[7:0];
         6'd26:   hdr_byte = cfg.source_ip[31:24];
         6'd27:   hdr_byte = cfg.source_ip[23:16];
         6'd28:   hdr_byte = cfg.source_ip[15:8];
         6'd29:   hdr_byte = cfg.source_ip[7:0];
         6'd30:   hdr_byte = dip_ff[31:24];
         6'd31:   hdr_byte = dip_ff[23:16];
         6'd32:   hdr_byte = dip_ff[15:8];
         6'd33:   hdr_byte = dip_ff[7:0];
         6'd34:   hdr_byte = sport_ff[15:8];
         6'd35:   hdr_byte = sport_ff[7:0];
         6'd36:   hdr_byte = dport_ff[15:8];
         6'd37:   hdr_byte = dport_ff[7:0];
         6'd38:   hdr_byte = udp_len[15:8];
         6'd39:   hdr_byte = udp_len[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      load     = 1'b0;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && out_room) begin
               cmd_pop = 1'b1;
               case (cmd_head.kind)
                  CMD_HDR: begin
                     load     = 1'b1;
                     state_in = BK_HDR;
                     idx_in   = '0;
                     sum_in   = CSUM_SEED + CSUM_W'(cmd_head.payload_len);
                  end
                  CMD_DATA: begin
                     out_push            = 1'b1;
                     out_data.frame_byte = cmd_head.data;
                     out_data.last       = cmd_head.last;
                  end
                  default: begin
                     out_push       = 1'b1;
                     out_data.last  = 1'b1;
                     out_data.error = 1'b1;
                  end
               endcase
            end
         end
         BK_HDR: begin
            if (out_room) begin
               out_push            = 1'b1;
               out_data.frame_byte = hdr_byte;
               out_data.last       = (idx_ff == LAST_IDX) && (len_ff == '0);
               idx_in              = idx_ff + IDX_W'(1);
               // checksum: add address words, then fold the carries twice
               case (idx_ff)
                  6'd0:    sum_in = sum_ff + CSUM_W'(cfg.source_ip[31:16]);
                  6'd1:    sum_in = sum_ff + CSUM_W'(cfg.source_ip[15:0]);
                  6'd2:    sum_in = sum_ff + CSUM_W'(dip_ff[31:16]);
                  6'd3:    sum_in = sum_ff + CSUM_W'(dip_ff[15:0]);
                  6'd4,
                  6'd5:    sum_in = CSUM_W'(sum_ff[15:0]) + CSUM_W'(sum_ff[CSUM_W-1:16]);
                  default: sum_in = sum_ff;
               endcase
               if (idx_ff == LAST_IDX) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      if (load) begin
         dip_ff   <= cmd_head.dest_ip;
         dport_ff <= cmd_head.dest_port;
         sport_ff <= cmd_head.source_port;
         len_ff   <= cmd_head.payload_len;
      end
   end

endmodule

`default_nettype wire

/* src/ufb_out_queue.sv */
// Result queue that parts the back end from the response port.
// Room is offered when a slot is free or the head leaves this cycle. Uses ufb_pkg.
`default_nettype none

module ufb_out_queue
   import ufb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  rsp_type   push_data,
   input  wire logic pop,
   output logic      room,
   output logic      empty,
   output rsp_type   head
);

   rsp_type              slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ff, rd_ff;
   logic [OUT_CNT_W-1:0] cnt_ff;
   logic                 pop_ok;

   assign empty  = (cnt_ff == '0);
   assign pop_ok = pop && !empty;
   assign room   = (cnt_ff != OUT_CNT_W'(OUT_DEPTH)) || pop_ok;
   assign head   = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ff + OUT_PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ff <= (rd_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ff + OUT_PTR_W'(1);
         end
         if (push && !pop_ok) begin
            cnt_ff <= cnt_ff + OUT_CNT_W'(1);
         end else if (pop_ok && !push) begin
            cnt_ff <= cnt_ff - OUT_CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* src/udp_ipv4_frame_builder_top.sv */
// UDP/IPv4/Ethernet frame builder, top level: configuration registers and
// the front end, command queue, header sequencer and result queue. Uses ufb_pkg.
//
// Usage:
//  - csr_*: write local MAC (0), gateway MAC (1) or source IP (2); always ready.
//    Write only while no frame bytes are pending.
//  - req_*: push a start beat (opcode 0) or a payload beat (opcode 1) when
//    req_full is low. A bad start or a payload beat with no open frame
//    gives one error beat (byte 0, last and error set).
//  - rsp_*: the oldest result beat sits on the ports while rsp_empty is low;
//    rsp_pop takes it.
// A payload or error beat passes the command queue and then the result queue
// before it shows on rsp_*. A good start gives 42 header bytes at one per cycle
// while the result queue has room; the sequencer loads the start, then sends them.
// Throughput: payload beats stream at one per cycle while the result queue has
// room; the front end fills its two-entry command queue while the header is sent.
// Reset: queues empty, no frame open, ephemeral port back to 49152, registers
// to their defaults. When rsp_pop stays low, the result queue fills, the
// sequencer holds, and req_full rises once the command queue is full.
`default_nettype none

module udp_ipv4_frame_builder_top
   import ufb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [47:0]          csr_wdata,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_opcode,
   input  wire logic [31:0]          req_dest_ip,
   input  wire logic [15:0]          req_dest_port,
   input  wire logic [15:0]          req_source_port,
   input  wire logic [LEN_W-1:0]     req_payload_len,
   input  wire logic [7:0]           req_payload_byte,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_frame_byte,
   output logic                      rsp_last,
   output logic                      rsp_error
);

   cfg_type cfg_ff;
   cmd_type cmd_in_data, cmd_head;
   rsp_type out_data, rsp_head;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic    out_push, out_room;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_mac   <= LOCAL_MAC_RST;
         cfg_ff.gateway_mac <= GATEWAY_MAC_RST;
         cfg_ff.source_ip   <= SOURCE_IP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOCAL_MAC:   cfg_ff.local_mac   <= csr_wdata;
            CSR_GATEWAY_MAC: cfg_ff.gateway_mac <= csr_wdata;
            CSR_SOURCE_IP:   cfg_ff.source_ip   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   ufb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_opcode       (req_opcode),
      .req_dest_ip      (req_dest_ip),
      .req_dest_port    (req_dest_port),
      .req_source_port  (req_source_port),
      .req_payload_len  (req_payload_len),
      .req_payload_byte (req_payload_byte),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in_data)
   );

   assign req_full = cmd_full;

   ufb_cmd_queue u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   ufb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .out_room  (out_room),
      .cmd_pop   (cmd_pop),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   ufb_out_queue u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .room      (out_room),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_frame_byte = rsp_head.frame_byte;
   assign rsp_last       = rsp_head.last;
   assign rsp_error      = rsp_head.error;

   // error beats always close with a zero byte
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_last && rsp_frame_byte == 8'h00))
      else $error("error beat without last or with nonzero byte");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_cmd_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!cmd_empty && out_room))
      else $error("command popped from empty queue or without result room");

   a_out_push: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_room)
      else $error("result pushed without room");

endmodule

`default_nettype wire
